/* src/imcg_pkg.sv */
// Shared types, register indexes and the reciprocal table of the im2col gather block.
package imcg_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_CHANNEL_COUNT = 3'd0;
   localparam logic [2:0] CSR_IMAGE_HEIGHT  = 3'd1;
   localparam logic [2:0] CSR_IMAGE_WIDTH   = 3'd2;
   localparam logic [2:0] CSR_KERNEL_SIZE   = 3'd3;
   localparam logic [2:0] CSR_PAD_AMOUNT    = 3'd4;
   localparam logic [2:0] CSR_STRIDE_STEP   = 3'd5;

   // Request operation codes.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // Fixed point shift of the reciprocal table.
   localparam int RECIP_SHIFT = 20;

   typedef struct packed {
      logic        operation;
      logic [15:0] pixel_address;
      logic [31:0] pixel_value;
      logic [15:0] col_row;
      logic [8:0]  out_y;
      logic [8:0]  out_x;
   } req_word_type;

   typedef struct packed {
      logic [31:0] element_value;
      logic        is_padding;
      logic        request_error;
   } rsp_word_type;

   // Effective geometry handed from the configuration unit to the gather sequencer.
   typedef struct packed {
      logic        busy;
      logic [8:0]  img_h;
      logic [8:0]  img_w;
      logic [3:0]  ker;
      logic [2:0]  pad;
      logic [3:0]  stride;
      logic [20:0] ker_recip;
      logic [15:0] row_limit;
      logic [24:0] pix_limit;
      logic [8:0]  out_h;
      logic [8:0]  out_w;
   } geom_type;

   typedef enum logic [1:0] {
      CFG_IDLE,
      CFG_STEP1,
      CFG_STEP2,
      CFG_STEP3
   } cfg_phase_type;

   typedef enum logic [3:0] {
      GAT_IDLE,
      GAT_WRITE,
      GAT_DIV1,
      GAT_DIV2,
      GAT_REM,
      GAT_POS,
      GAT_ADDR,
      GAT_READ,
      GAT_WAIT,
      GAT_DONE
   } gat_state_type;

   // ceil(2^20 / d): floor(n * recip >> 20) equals n / d for every 16-bit n.
   // A divisor of zero acts as one.
   function automatic logic [20:0] recip_of(input logic [3:0] d);
      logic [20:0] r;
      unique case (d)
         4'd0, 4'd1: r = 21'd1048576;
         4'd2:       r = 21'd524288;
         4'd3:       r = 21'd349526;
         4'd4:       r = 21'd262144;
         4'd5:       r = 21'd209716;
         4'd6:       r = 21'd174763;
         4'd7:       r = 21'd149797;
         4'd8:       r = 21'd131072;
         4'd9:       r = 21'd116509;
         4'd10:      r = 21'd104858;
         4'd11:      r = 21'd95326;
         4'd12:      r = 21'd87382;
         4'd13:      r = 21'd80660;
         4'd14:      r = 21'd74899;
         4'd15:      r = 21'd69906;
      endcase
      return r;
   endfunction

endpackage

/* src/imcg_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module imcg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/imcg_cfg.sv */
// Configuration registers and the derived geometry limits, recomputed after each write.
module imcg_cfg (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_data,
   output imcg_pkg::geom_type geom
);

   imcg_pkg::cfg_phase_type phase_ff, phase_in;

   logic [8:0]  ch_raw_ff, ch_raw_in;
   logic [8:0]  h_raw_ff, h_raw_in;
   logic [8:0]  w_raw_ff, w_raw_in;
   logic [3:0]  k_raw_ff, k_raw_in;
   logic [2:0]  p_raw_ff, p_raw_in;
   logic [3:0]  s_raw_ff, s_raw_in;

   logic [8:0]  ch_eff, h_eff, w_eff;
   logic [3:0]  k_eff, s_eff;

   logic [7:0]  kk_ff, kk_in;
   logic [16:0] chh_ff, chh_in;
   logic [8:0]  span_h_ff, span_h_in;
   logic [8:0]  span_w_ff, span_w_in;
   logic [20:0] rk_ff, rk_in;
   logic [20:0] rs_ff, rs_in;
   logic [15:0] row_lim_ff, row_lim_in;
   logic [24:0] pix_lim_ff, pix_lim_in;
   logic        lt_h_ff, lt_h_in;
   logic        lt_w_ff, lt_w_in;
   logic [8:0]  qh_ff, qh_in;
   logic [8:0]  qw_ff, qw_in;
   logic [8:0]  oh_ff, oh_in;
   logic [8:0]  ow_ff, ow_in;

   logic        wr_fire;
   logic [16:0] row_prod;
   logic [25:0] pix_prod;
   logic [8:0]  diff_h, diff_w;
   logic [29:0] quot_h, quot_w;

   function automatic logic [8:0] clamp_dim(input logic [8:0] v);
      logic [8:0] r;
      if (v == 9'd0) begin
         r = 9'd1;
      end else if (v > 9'd256) begin
         r = 9'd256;
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign ch_eff = clamp_dim(ch_raw_ff);
   assign h_eff  = clamp_dim(h_raw_ff);
   assign w_eff  = clamp_dim(w_raw_ff);
   assign k_eff  = (k_raw_ff == 4'd0) ? 4'd1 : k_raw_ff;
   assign s_eff  = (s_raw_ff == 4'd0) ? 4'd1 : s_raw_ff;

   assign csr_ready = (phase_ff == imcg_pkg::CFG_IDLE);
   assign wr_fire   = csr_valid && csr_ready;

   always_comb begin
      ch_raw_in = ch_raw_ff;
      h_raw_in  = h_raw_ff;
      w_raw_in  = w_raw_ff;
      k_raw_in  = k_raw_ff;
      p_raw_in  = p_raw_ff;
      s_raw_in  = s_raw_ff;
      if (wr_fire) begin
         unique case (csr_index)
            imcg_pkg::CSR_CHANNEL_COUNT: ch_raw_in = csr_data[8:0];
            imcg_pkg::CSR_IMAGE_HEIGHT:  h_raw_in  = csr_data[8:0];
            imcg_pkg::CSR_IMAGE_WIDTH:   w_raw_in  = csr_data[8:0];
            imcg_pkg::CSR_KERNEL_SIZE:   k_raw_in  = csr_data[3:0];
            imcg_pkg::CSR_PAD_AMOUNT:    p_raw_in  = csr_data[2:0];
            imcg_pkg::CSR_STRIDE_STEP:   s_raw_in  = csr_data[3:0];
            default: ;
         endcase
      end

      if (wr_fire) begin
         phase_in = imcg_pkg::CFG_STEP1;
      end else begin
         unique case (phase_ff)
            imcg_pkg::CFG_STEP1: phase_in = imcg_pkg::CFG_STEP2;
            imcg_pkg::CFG_STEP2: phase_in = imcg_pkg::CFG_STEP3;
            imcg_pkg::CFG_STEP3: phase_in = imcg_pkg::CFG_IDLE;
            imcg_pkg::CFG_IDLE:  phase_in = imcg_pkg::CFG_IDLE;
         endcase
      end
   end

   // The limits run through three register stages and have settled once busy drops after a write.
   always_comb begin
      kk_in     = 8'(k_eff) * 8'(k_eff);
      chh_in    = 17'(ch_eff) * 17'(h_eff);
      span_h_in = h_eff + 9'({p_raw_ff, 1'b0});
      span_w_in = w_eff + 9'({p_raw_ff, 1'b0});
      rk_in     = imcg_pkg::recip_of(k_eff);
      rs_in     = imcg_pkg::recip_of(s_eff);

      row_prod   = 17'(ch_eff) * 17'(kk_ff);
      row_lim_in = row_prod[15:0];
      pix_prod   = 26'(chh_ff) * 26'(w_eff);
      pix_lim_in = pix_prod[24:0];
      lt_h_in    = span_h_ff < 9'(k_eff);
      lt_w_in    = span_w_ff < 9'(k_eff);
      diff_h     = lt_h_in ? 9'd0 : (span_h_ff - 9'(k_eff));
      diff_w     = lt_w_in ? 9'd0 : (span_w_ff - 9'(k_eff));
      quot_h     = 30'(diff_h) * 30'(rs_ff);
      quot_w     = 30'(diff_w) * 30'(rs_ff);
      qh_in      = quot_h[28:20];
      qw_in      = quot_w[28:20];

      oh_in = lt_h_ff ? 9'd0 : (qh_ff + 9'd1);
      ow_in = lt_w_ff ? 9'd0 : (qw_ff + 9'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= imcg_pkg::CFG_IDLE;
         ch_raw_ff  <= 9'd1;
         h_raw_ff   <= 9'd1;
         w_raw_ff   <= 9'd1;
         k_raw_ff   <= 4'd1;
         p_raw_ff   <= 3'd0;
         s_raw_ff   <= 4'd1;
         kk_ff      <= 8'd1;
         chh_ff     <= 17'd1;
         span_h_ff  <= 9'd1;
         span_w_ff  <= 9'd1;
         rk_ff      <= imcg_pkg::recip_of(4'd1);
         rs_ff      <= imcg_pkg::recip_of(4'd1);
         row_lim_ff <= 16'd1;
         pix_lim_ff <= 25'd1;
         lt_h_ff    <= 1'b0;
         lt_w_ff    <= 1'b0;
         qh_ff      <= 9'd0;
         qw_ff      <= 9'd0;
         oh_ff      <= 9'd1;
         ow_ff      <= 9'd1;
      end else begin
         phase_ff   <= phase_in;
         ch_raw_ff  <= ch_raw_in;
         h_raw_ff   <= h_raw_in;
         w_raw_ff   <= w_raw_in;
         k_raw_ff   <= k_raw_in;
         p_raw_ff   <= p_raw_in;
         s_raw_ff   <= s_raw_in;
         kk_ff      <= kk_in;
         chh_ff     <= chh_in;
         span_h_ff  <= span_h_in;
         span_w_ff  <= span_w_in;
         rk_ff      <= rk_in;
         rs_ff      <= rs_in;
         row_lim_ff <= row_lim_in;
         pix_lim_ff <= pix_lim_in;
         lt_h_ff    <= lt_h_in;
         lt_w_ff    <= lt_w_in;
         qh_ff      <= qh_in;
         qw_ff      <= qw_in;
         oh_ff      <= oh_in;
         ow_ff      <= ow_in;
      end
   end

   always_comb begin
      geom.busy      = (phase_ff != imcg_pkg::CFG_IDLE);
      geom.img_h     = h_eff;
      geom.img_w     = w_eff;
      geom.ker       = k_eff;
      geom.pad       = p_raw_ff;
      geom.stride    = s_eff;
      geom.ker_recip = rk_ff;
      geom.row_limit = row_lim_ff;
      geom.pix_limit = pix_lim_ff;
      geom.out_h     = oh_ff;
      geom.out_w     = ow_ff;
   end

endmodule

/* src/imcg_gather.sv */
// Per-word sequencer: range checks, row split, address build and image store access.
module imcg_gather #(
   parameter int STORE_DEPTH   = 65536,
   parameter int ELEMENT_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  imcg_pkg::req_word_type           req_word,
   input  imcg_pkg::geom_type               geom,
   output logic                             idle,
   output logic                             done,
   input  logic                             take,
   output imcg_pkg::rsp_word_type           rsp_word,
   output logic                             mem_wr_en,
   output logic [$clog2(STORE_DEPTH)-1:0]   mem_wr_addr,
   output logic [ELEMENT_WIDTH-1:0]         mem_wr_data,
   output logic                             mem_rd_en,
   output logic [$clog2(STORE_DEPTH)-1:0]   mem_rd_addr,
   input  logic [ELEMENT_WIDTH-1:0]         mem_rd_data
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam logic [24:0] DEPTH_LIM = 25'(STORE_DEPTH);

   imcg_pkg::gat_state_type state_ff, state_in;

   imcg_pkg::req_word_type item_ff, item_in;
   logic [15:0] q1_ff, q1_in;
   logic [12:0] oys_ff, oys_in;
   logic [12:0] oxs_ff, oxs_in;
   logic [7:0]  c_ff, c_in;
   logic [3:0]  kc_ff, kc_in;
   logic [3:0]  kr_ff, kr_in;
   logic [16:0] chh_ff, chh_in;
   logic [16:0] base_ff, base_in;
   logic [8:0]  x_ff, x_in;
   logic [24:0] addr_ff, addr_in;
   logic        hit_ff, hit_in;
   logic [31:0] value_ff, value_in;
   logic        pad_ff, pad_in;
   logic        err_ff, err_in;

   logic [24:0] wr_addr_wide;
   logic        wr_bad;
   logic [63:0] wr_data_wide;
   logic [63:0] rd_data_wide;
   logic [36:0] q1_prod;
   logic [36:0] c_prod;
   logic [19:0] q1k_prod;
   logic [15:0] rem1;
   logic [11:0] ck_prod;
   logic [15:0] rem2;
   logic [13:0] ysum, xsum, ydiff, xdiff;
   logic        pad_y, pad_x;
   logic [25:0] addr_prod;
   logic [25:0] addr_sum;
   logic        rd_go;

   assign wr_addr_wide = 25'(item_ff.pixel_address);
   assign wr_bad       = (wr_addr_wide >= DEPTH_LIM) || (wr_addr_wide >= geom.pix_limit);
   assign wr_data_wide = 64'(item_ff.pixel_value);
   assign rd_data_wide = 64'(mem_rd_data);

   // Division by the kernel side goes through a reciprocal multiply.
   assign q1_prod  = 37'(item_ff.col_row) * 37'(geom.ker_recip);
   assign c_prod   = 37'(q1_ff) * 37'(geom.ker_recip);
   assign q1k_prod = 20'(q1_ff) * 20'(geom.ker);
   assign rem1     = item_ff.col_row - q1k_prod[15:0];
   assign ck_prod  = 12'(c_ff) * 12'(geom.ker);
   assign rem2     = q1_ff - 16'(ck_prod);

   assign ysum  = 14'(oys_ff) + 14'(kr_ff);
   assign xsum  = 14'(oxs_ff) + 14'(kc_ff);
   assign ydiff = ysum - 14'(geom.pad);
   assign xdiff = xsum - 14'(geom.pad);
   assign pad_y = (ysum < 14'(geom.pad)) || (ydiff >= 14'(geom.img_h));
   assign pad_x = (xsum < 14'(geom.pad)) || (xdiff >= 14'(geom.img_w));

   assign addr_prod = 26'(base_ff) * 26'(geom.img_w);
   assign addr_sum  = addr_prod + 26'(x_ff);

   assign rd_go = (state_ff == imcg_pkg::GAT_READ) && !err_ff && !pad_ff
                  && (addr_ff < DEPTH_LIM);

   assign mem_wr_en   = (state_ff == imcg_pkg::GAT_WRITE) && !wr_bad;
   assign mem_wr_addr = wr_addr_wide[AW-1:0];
   assign mem_wr_data = wr_data_wide[ELEMENT_WIDTH-1:0];
   assign mem_rd_en   = rd_go;
   assign mem_rd_addr = addr_ff[AW-1:0];

   assign idle = (state_ff == imcg_pkg::GAT_IDLE);
   assign done = (state_ff == imcg_pkg::GAT_DONE);

   always_comb begin
      rsp_word.element_value = value_ff;
      rsp_word.is_padding    = pad_ff;
      rsp_word.request_error = err_ff;
   end

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      q1_in    = q1_ff;
      oys_in   = oys_ff;
      oxs_in   = oxs_ff;
      c_in     = c_ff;
      kc_in    = kc_ff;
      kr_in    = kr_ff;
      chh_in   = chh_ff;
      base_in  = base_ff;
      x_in     = x_ff;
      addr_in  = addr_ff;
      hit_in   = hit_ff;
      value_in = value_ff;
      pad_in   = pad_ff;
      err_in   = err_ff;

      unique case (state_ff)
         imcg_pkg::GAT_IDLE: begin
            if (start) begin
               item_in  = req_word;
               state_in = (req_word.operation == imcg_pkg::OP_WRITE) ?
                          imcg_pkg::GAT_WRITE : imcg_pkg::GAT_DIV1;
            end
         end
         imcg_pkg::GAT_WRITE: begin
            value_in = 32'd0;
            pad_in   = 1'b0;
            err_in   = wr_bad;
            state_in = imcg_pkg::GAT_DONE;
         end
         imcg_pkg::GAT_DIV1: begin
            q1_in    = q1_prod[35:20];
            oys_in   = 13'(item_ff.out_y) * 13'(geom.stride);
            oxs_in   = 13'(item_ff.out_x) * 13'(geom.stride);
            err_in   = (item_ff.col_row >= geom.row_limit)
                       || (item_ff.out_y >= geom.out_h)
                       || (item_ff.out_x >= geom.out_w);
            state_in = imcg_pkg::GAT_DIV2;
         end
         imcg_pkg::GAT_DIV2: begin
            // Channel is below 256 whenever the row passed its range check.
            c_in     = c_prod[27:20];
            kc_in    = rem1[3:0];
            state_in = imcg_pkg::GAT_REM;
         end
         imcg_pkg::GAT_REM: begin
            kr_in    = rem2[3:0];
            chh_in   = 17'(c_ff) * 17'(geom.img_h);
            state_in = imcg_pkg::GAT_POS;
         end
         imcg_pkg::GAT_POS: begin
            pad_in   = !err_ff && (pad_y || pad_x);
            base_in  = chh_ff + 17'(ydiff[8:0]);
            x_in     = xdiff[8:0];
            state_in = imcg_pkg::GAT_ADDR;
         end
         imcg_pkg::GAT_ADDR: begin
            addr_in  = addr_sum[24:0];
            state_in = imcg_pkg::GAT_READ;
         end
         imcg_pkg::GAT_READ: begin
            hit_in   = rd_go;
            err_in   = err_ff || (!pad_ff && (addr_ff >= DEPTH_LIM));
            state_in = imcg_pkg::GAT_WAIT;
         end
         imcg_pkg::GAT_WAIT: begin
            value_in = hit_ff ? rd_data_wide[31:0] : 32'd0;
            state_in = imcg_pkg::GAT_DONE;
         end
         imcg_pkg::GAT_DONE: begin
            if (take) begin
               state_in = imcg_pkg::GAT_IDLE;
            end
         end
         default: state_in = imcg_pkg::GAT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imcg_pkg::GAT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      q1_ff    <= q1_in;
      oys_ff   <= oys_in;
      oxs_ff   <= oxs_in;
      c_ff     <= c_in;
      kc_ff    <= kc_in;
      kr_ff    <= kr_in;
      chh_ff   <= chh_in;
      base_ff  <= base_in;
      x_ff     <= x_in;
      addr_ff  <= addr_in;
      hit_ff   <= hit_in;
      value_ff <= value_in;
      pad_ff   <= pad_in;
      err_ff   <= err_in;
   end

endmodule

/* src/im2col_gather_core.sv */
// Top level of the im2col gather block: handshakes, output register and store instance.
//
// The block holds a multi-channel image in an on-chip store and serves single elements
// of the im2col column matrix. A request word on the req_ channel either writes one
// image element at a flat address or names a column matrix row and an output window
// position; exactly one response word comes back on the rsp_ channel for each request.
// The csr_ port writes the geometry registers (channels, height, width, kernel, pad,
// stride); it drops ready after a write while the output sizes and range limits are
// recomputed, and requests are held off during that time.
// Requests are served one at a time by a sequencer around the store. A write passes
// through its write and done states, and a read through a chain of reciprocal-multiply
// division by the kernel side, the address multiplies and the registered store read.
// The response word sits in an output register, so the sequencer takes the next
// request while the receiver stalls; a further response waits in the sequencer
// until the register frees up, and req_stall stays high meanwhile.
// Reset clears control state and loads the register reset values; store contents
// are unknown until written.
module im2col_gather_core #(
   parameter int STORE_DEPTH   = 65536,
   parameter int ELEMENT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  imcg_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output imcg_pkg::rsp_word_type rsp_word,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [2:0]             csr_index,
   input  logic [15:0]            csr_data
);

   localparam int AW = $clog2(STORE_DEPTH);

   imcg_pkg::geom_type     geom;
   imcg_pkg::rsp_word_type gat_word;
   logic                   gat_idle;
   logic                   gat_done;
   logic                   gat_take;
   logic                   start;

   logic                   mem_wr_en;
   logic [AW-1:0]          mem_wr_addr;
   logic [ELEMENT_WIDTH-1:0] mem_wr_data;
   logic                   mem_rd_en;
   logic [AW-1:0]          mem_rd_addr;
   logic [ELEMENT_WIDTH-1:0] mem_rd_data;

   logic                   rsp_valid_ff, rsp_valid_in;
   imcg_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   // A request is held off while the sequencer is busy, while the geometry settles,
   // and in a cycle that carries a register write.
   assign req_stall = !gat_idle || geom.busy || csr_valid;
   assign start     = req_valid && !req_stall;

   // The output register loads when it is empty or being drained this cycle.
   assign gat_take = gat_done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_word_in = rsp_word_ff;
      if (gat_take) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = gat_word;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   imcg_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .geom      (geom)
   );

   imcg_gather #(
      .STORE_DEPTH   (STORE_DEPTH),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_gather (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_word    (req_word),
      .geom        (geom),
      .idle        (gat_idle),
      .done        (gat_done),
      .take        (gat_take),
      .rsp_word    (gat_word),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   imcg_ram #(
      .WIDTH (ELEMENT_WIDTH),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule
